>>> sv/dwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwc_pkg - shared types and constants of the weighed dose dispense controller
// Command, status and phase codes, field widths, register indexes and the
// structs that pass configuration and result status between the modules.
// ----------------------------------------------------------------------------
package dwc_pkg;

   localparam int VOL_W      = 16;
   localparam int DENSITY_W  = 12;
   localparam int SPM_W      = 8;
   localparam int PCT_W      = 7;
   localparam int TARGET_W   = 27;
   localparam int BUDGET_W   = 25;
   localparam int COUNT_W    = 16;
   localparam int SERVO_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [TARGET_W-1:0]  TARGET_MAX   = {TARGET_W{1'b1}};
   localparam logic [SERVO_W-1:0]   SERVO_OPEN   = 8'd96;
   localparam logic [SERVO_W-1:0]   SERVO_CLOSED = 8'd32;
   localparam logic [PCT_W-1:0]     PCT_FULL     = 7'd100;

   localparam logic [DENSITY_W-1:0] DENSITY_RESET = 12'd1330;
   localparam logic [SPM_W-1:0]     SPM_RESET     = 8'd2;
   localparam logic [PCT_W-1:0]     PCT_RESET     = 7'd20;

   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPM     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PCT     = 2'd2;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_OPEN  = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NONE    = 3'd0,
      ST_OK      = 3'd1,
      ST_PARTIAL = 3'd2,
      ST_CLOG    = 3'd3,
      ST_IGNORED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DISP  = 2'd1,
      PH_FINAL = 2'd2,
      PH_ERROR = 2'd3
   } phase_type;

   typedef struct packed {
      logic [DENSITY_W-1:0] density;
      logic [SPM_W-1:0]     spm;
      logic [PCT_W-1:0]     pct;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic               valve_on;
      phase_type          phase;
      logic               clog;
      logic [COUNT_W-1:0] dose_count;
   } stat_type;

endpackage : dwc_pkg
`default_nettype wire

>>> sv/dwc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwc_engine - dose state and single-pass update
// Holds the dose state and computes, from the item in the input register,
// the next state and the result status in one pass.
// ----------------------------------------------------------------------------
module dwc_engine
   import dwc_pkg::*;
#(
   parameter int WEIGHT_BITS = 26
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           fire,
   input  cfg_type                       cfg,
   input  cmd_type                       cmd,
   input  wire        [VOL_W-1:0]        volume,
   input  wire signed [WEIGHT_BITS-1:0]  weight,
   output stat_type                      res_stat,
   output logic signed [WEIGHT_BITS-1:0] res_weight
);

   // difference width: loss is one bit wider than a weight, target is 27 bits
   localparam int LW = (WEIGHT_BITS + 1 > TARGET_W + 1) ? WEIGHT_BITS + 1 : TARGET_W + 1;
   localparam int DW = LW + 1;
   localparam int PW = DW + PCT_W;

   phase_type                     phase_ff, phase_in;
   logic signed [WEIGHT_BITS-1:0] start_ff, start_in;
   logic [TARGET_W-1:0]           target_ff, target_in;
   logic [BUDGET_W-1:0]           budget_ff, budget_in;
   logic [BUDGET_W-1:0]           taken_ff, taken_in;
   logic                          valve_ff, valve_in;
   logic                          clog_ff, clog_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic signed [WEIGHT_BITS-1:0] good_ff, good_in;
   status_type                    status_in;

   logic                          busy;
   logic [VOL_W+DENSITY_W-1:0]    target_raw;
   logic [VOL_W+SPM_W-1:0]        budget_raw;
   logic [BUDGET_W-1:0]           taken_inc;
   logic signed [DW-1:0]          loss;
   logic signed [DW-1:0]          target_s;
   logic signed [DW-1:0]          diff;
   logic [DW-1:0]                 diff_abs;
   logic [PW-1:0]                 err_x100;
   logic [PCT_W+TARGET_W-1:0]     allow_raw;
   logic [PW-1:0]                 allow;
   logic                          clog_hit;

   always_comb begin
      busy       = (phase_ff == PH_DISP) || (phase_ff == PH_FINAL);
      target_raw = volume * cfg.density;
      budget_raw = volume * cfg.spm;
      taken_inc  = taken_ff + 1'b1;
      loss       = DW'(start_ff) - DW'(weight);
      target_s   = signed'(DW'(target_ff));
      diff       = loss - target_s;
      diff_abs   = diff[DW-1] ? DW'(-diff) : DW'(diff);
      // times 100 as 64 + 32 + 4
      err_x100   = (PW'(diff_abs) << 6) + (PW'(diff_abs) << 5) + (PW'(diff_abs) << 2);
      allow_raw  = cfg.pct * target_ff;
      allow      = PW'(allow_raw);
      if (target_ff != '0) begin
         clog_hit = err_x100 > allow;
      end else begin
         clog_hit = PCT_FULL > cfg.pct;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      target_in = target_ff;
      budget_in = budget_ff;
      taken_in  = taken_ff;
      valve_in  = valve_ff;
      clog_in   = clog_ff;
      count_in  = count_ff;
      good_in   = good_ff;
      status_in = ST_NONE;
      case (cmd)
         CMD_START: begin
            if (busy) begin
               status_in = ST_IGNORED;
            end else begin
               start_in  = weight;
               target_in = (target_raw > (VOL_W+DENSITY_W)'(TARGET_MAX)) ?
                           TARGET_MAX : TARGET_W'(target_raw);
               budget_in = BUDGET_W'(budget_raw);
               taken_in  = '0;
               if (budget_raw == '0) begin
                  valve_in = 1'b0;
                  phase_in = PH_FINAL;
               end else begin
                  valve_in = 1'b1;
                  phase_in = PH_DISP;
               end
            end
         end
         CMD_TICK: begin
            if (phase_ff == PH_DISP) begin
               taken_in = taken_inc;
               if (loss >= target_s) begin
                  valve_in  = 1'b0;
                  good_in   = weight;
                  phase_in  = PH_IDLE;
                  count_in  = count_ff + 1'b1;
                  status_in = ST_OK;
               end else if (taken_inc >= budget_ff) begin
                  valve_in = 1'b0;
                  phase_in = PH_FINAL;
               end
            end else if (phase_ff == PH_FINAL) begin
               if (clog_hit) begin
                  clog_in   = 1'b1;
                  phase_in  = PH_ERROR;
                  status_in = ST_CLOG;
               end else begin
                  phase_in  = PH_IDLE;
                  status_in = ST_PARTIAL;
               end
            end
         end
         CMD_OPEN, CMD_CLOSE: begin
            if (busy) begin
               status_in = ST_IGNORED;
            end else begin
               valve_in = (cmd == CMD_OPEN);
            end
         end
         default: begin
            status_in = ST_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         start_ff  <= '0;
         target_ff <= '0;
         budget_ff <= '0;
         taken_ff  <= '0;
         valve_ff  <= 1'b0;
         clog_ff   <= 1'b0;
         count_ff  <= '0;
         good_ff   <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         target_ff <= target_in;
         budget_ff <= budget_in;
         taken_ff  <= taken_in;
         valve_ff  <= valve_in;
         clog_ff   <= clog_in;
         count_ff  <= count_in;
         good_ff   <= good_in;
      end
   end

   always_comb begin
      res_stat.status     = status_in;
      res_stat.valve_on   = valve_in;
      res_stat.phase      = phase_in;
      res_stat.clog       = clog_in;
      res_stat.dose_count = count_in;
      res_weight          = good_in;
   end

endmodule : dwc_engine
`default_nettype wire

>>> sv/weighed_dose_dispense_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighed_dose_dispense_controller_unit - weighed dose valve controller
// Opens a valve on a start command, watches load cell weight samples and
// closes it on target weight loss or sample budget timeout, reporting
// success, partial dose or clog.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake        | Contents
//  --------+-----------+------------------+--------------------------------
//  req     | in        | tvalid / tready  | tuser: command; tdata: volume,
//          |           |                  | weight
//  rsp     | out       | tvalid / tready  | tdata: one result item per item
//  csr     | in        | csr_we           | register index and write data
//
//  rsp_tvalid rises once an accepted item has gone through one input
//  register, one pass of the dose update and one result register.
//  One item per cycle is sustained while rsp is ready; the update of the dose
//  state is a single pass, so each item sees the state left by the one before it.
//  rsp stalls hold the result register; the input register still takes one
//  more item, then req_tready drops until the result is taken.
//  Synchronous reset clears the dose state, counters, sticky clog flag and
//  restores the register defaults.
//
module weighed_dose_dispense_controller_unit
   import dwc_pkg::*;
#(
   parameter  int WEIGHT_BITS = 26,
   localparam int REQ_USED    = VOL_W + WEIGHT_BITS,
   localparam int REQ_DATA_W  = ((REQ_USED + 7) / 8) * 8,
   localparam int RSP_USED    = 3 + 1 + SERVO_W + 2 + 1 + COUNT_W + WEIGHT_BITS,
   localparam int RSP_DATA_W  = ((RSP_USED + 7) / 8) * 8
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire [REQ_DATA_W-1:0]  req_tdata,   // volume_ml, weight_mg, zero pad
   input  wire [1:0]             req_tuser,   // command
   // result channel
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status, valve_is_open,
                                              // servo_compare, phase, clog_flag,
                                              // dose_count, final_weight_mg, pad
   // configuration writes
   input  wire                   csr_we,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.density <= DENSITY_RESET;
         cfg_ff.spm     <= SPM_RESET;
         cfg_ff.pct     <= PCT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DENSITY: cfg_ff.density <= csr_wdata[DENSITY_W-1:0];
            CSR_SPM:     cfg_ff.spm     <= csr_wdata[SPM_W-1:0];
            CSR_PCT:     cfg_ff.pct     <= csr_wdata[PCT_W-1:0];
            default:     cfg_ff         <= cfg_ff;
         endcase
      end
   end

   // input register
   logic                          in_valid_ff, in_valid_in;
   cmd_type                       in_cmd_ff;
   logic [VOL_W-1:0]              in_vol_ff;
   logic signed [WEIGHT_BITS-1:0] in_weight_ff;

   // result register
   logic                          out_valid_ff, out_valid_in;
   stat_type                      out_stat_ff;
   logic signed [WEIGHT_BITS-1:0] out_weight_ff;

   logic                          req_fire;
   logic                          advance;
   stat_type                      res_stat;
   logic signed [WEIGHT_BITS-1:0] res_weight;

   // advance the held item whenever the result register is free or draining
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      req_fire     = req_tvalid && req_tready;
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff    <= cmd_type'(req_tuser);
         in_vol_ff    <= req_tdata[VOL_W-1:0];
         in_weight_ff <= req_tdata[REQ_USED-1:VOL_W];
      end
      if (advance) begin
         out_stat_ff   <= res_stat;
         out_weight_ff <= res_weight;
      end
   end

   dwc_engine #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .cfg        (cfg_ff),
      .cmd        (in_cmd_ff),
      .volume     (in_vol_ff),
      .weight     (in_weight_ff),
      .res_stat   (res_stat),
      .res_weight (res_weight)
   );

   // pack the result item, lowest field first, zero pad on top
   always_comb begin
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = '0;
      rsp_tdata[RSP_USED-1:0] = {
         out_weight_ff,
         out_stat_ff.dose_count,
         out_stat_ff.clog,
         out_stat_ff.phase,
         (out_stat_ff.valve_on ? SERVO_OPEN : SERVO_CLOSED),
         out_stat_ff.valve_on,
         out_stat_ff.status
      };
   end

   // a dose in progress always has the valve commanded open
   a_disp_valve_open : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stat_ff.phase == PH_DISP) |-> out_stat_ff.valve_on)
      else $error("dispensing phase reported with valve closed");

   // awaiting the final sample means the valve has been shut
   a_final_valve_closed : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stat_ff.phase == PH_FINAL) |-> !out_stat_ff.valve_on)
      else $error("final sample phase reported with valve open");

   // a clog result lands in the error phase with the sticky flag set
   a_clog_error : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stat_ff.status == ST_CLOG) |->
      (out_stat_ff.clog && out_stat_ff.phase == PH_ERROR))
      else $error("clog result without sticky flag or error phase");

   // a successful dose closes the valve and returns to idle
   a_ok_idle : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stat_ff.status == ST_OK) |->
      (!out_stat_ff.valve_on && out_stat_ff.phase == PH_IDLE))
      else $error("dose ok result with valve open or not idle");

endmodule : weighed_dose_dispense_controller_unit
`default_nettype wire

>>> tb/dose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dose_checker - result checker for the weighed dose dispense controller
// Watches the request, result and register write ports, keeps its own copy
// of the dose state and registers, computes the result of every accepted
// item and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module dose_checker
   import dwc_pkg::*;
#(
   parameter int WEIGHT_BITS = 26,
   localparam int REQ_W = ((VOL_W + WEIGHT_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((3 + 1 + SERVO_W + 2 + 1 + COUNT_W + WEIGHT_BITS + 7) / 8) * 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tready,
   input  wire [REQ_W-1:0]      req_tdata,
   input  wire [1:0]            req_tuser,
   input  wire                  rsp_tvalid,
   input  wire                  rsp_tready,
   input  wire [RSP_W-1:0]      rsp_tdata,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata,
   output int                   fail_total,
   output int                   reports_due
);

   typedef struct packed {
      status_type               status;
      logic                     valve_on;
      logic [SERVO_W-1:0]       servo;
      phase_type                phase;
      logic                     clog;
      logic [COUNT_W-1:0]       doses;
      logic [WEIGHT_BITS-1:0]   last_weight;
   } dose_report_type;

   // dose state and register copy
   cfg_type                        cfg;
   phase_type                      run_phase;
   logic signed [WEIGHT_BITS-1:0]  start_w;
   logic [TARGET_W-1:0]            target;
   logic [BUDGET_W-1:0]            budget;
   logic [BUDGET_W-1:0]            taken;
   logic                           valve;
   logic                           clog_seen;
   logic [COUNT_W-1:0]             good_doses;
   logic signed [WEIGHT_BITS-1:0]  good_w;

   dose_report_type dose_reports_due[$];
   int              mismatches;
   int              result_no;

   function automatic dose_report_type next_dose_report(cmd_type cmd, logic [VOL_W-1:0] vol,
                                                        logic signed [WEIGHT_BITS-1:0] w);
      dose_report_type rep;
      longint          tgt;
      longint          loss;
      longint          dev;
      logic            busy;
      logic            is_clog;
      rep.status = ST_NONE;
      busy = (run_phase == PH_DISP) || (run_phase == PH_FINAL);
      case (cmd)
         CMD_START: begin
            if (busy) begin
               rep.status = ST_IGNORED;
            end else begin
               tgt = longint'(vol) * longint'(cfg.density);
               if (tgt > longint'(TARGET_MAX))
                  tgt = longint'(TARGET_MAX);
               start_w   = w;
               target    = tgt[TARGET_W-1:0];
               budget    = BUDGET_W'(longint'(vol) * longint'(cfg.spm));
               taken     = '0;
               valve     = 1'b1;
               run_phase = PH_DISP;
               if (budget == '0) begin
                  valve     = 1'b0;
                  run_phase = PH_FINAL;
               end
            end
         end
         CMD_TICK: begin
            loss = longint'(start_w) - longint'(w);
            tgt  = longint'(target);
            if (run_phase == PH_DISP) begin
               taken = taken + 1'b1;
               if (loss >= tgt) begin
                  valve      = 1'b0;
                  good_w     = w;
                  run_phase  = PH_IDLE;
                  good_doses = good_doses + 1'b1;
                  rep.status = ST_OK;
               end else if (taken >= budget) begin
                  valve     = 1'b0;
                  run_phase = PH_FINAL;
               end
            end else if (run_phase == PH_FINAL) begin
               if (tgt > 0) begin
                  dev = loss - tgt;
                  if (dev < 0)
                     dev = -dev;
                  is_clog = (dev * 100) > (longint'(cfg.pct) * tgt);
               end else begin
                  // no target at all: the error counts as full scale
                  is_clog = PCT_FULL > cfg.pct;
               end
               if (is_clog) begin
                  clog_seen  = 1'b1;
                  run_phase  = PH_ERROR;
                  rep.status = ST_CLOG;
               end else begin
                  run_phase  = PH_IDLE;
                  rep.status = ST_PARTIAL;
               end
            end
         end
         default: begin
            if (busy)
               rep.status = ST_IGNORED;
            else
               valve = (cmd == CMD_OPEN);
         end
      endcase
      rep.valve_on    = valve;
      rep.servo       = valve ? SERVO_OPEN : SERVO_CLOSED;
      rep.phase       = run_phase;
      rep.clog        = clog_seen;
      rep.doses       = good_doses;
      rep.last_weight = good_w;
      return rep;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("dose result %0d: %s expected %0d got %0d", result_no, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      dose_report_type want;
      dose_report_type got;
      if (reset) begin
         cfg        = '{density: DENSITY_RESET, spm: SPM_RESET, pct: PCT_RESET};
         run_phase  = PH_IDLE;
         start_w    = '0;
         target     = '0;
         budget     = '0;
         taken      = '0;
         valve      = 1'b0;
         clog_seen  = 1'b0;
         good_doses = '0;
         good_w     = '0;
         mismatches = 0;
         result_no  = 0;
         dose_reports_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DENSITY: cfg.density = csr_wdata[DENSITY_W-1:0];
               CSR_SPM:     cfg.spm     = csr_wdata[SPM_W-1:0];
               CSR_PCT:     cfg.pct     = csr_wdata[PCT_W-1:0];
               default:     ;
            endcase
         end
         if (req_tvalid && req_tready)
            dose_reports_due.push_back(next_dose_report(cmd_type'(req_tuser),
                                                        req_tdata[VOL_W-1:0],
                                                        req_tdata[VOL_W +: WEIGHT_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            result_no++;
            if (dose_reports_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("dose result %0d: arrived with nothing pending", result_no);
            end else begin
               want = dose_reports_due.pop_front();
               got.status      = status_type'(rsp_tdata[2:0]);
               got.valve_on    = rsp_tdata[3];
               got.servo       = rsp_tdata[11:4];
               got.phase       = phase_type'(rsp_tdata[13:12]);
               got.clog        = rsp_tdata[14];
               got.doses       = rsp_tdata[30:15];
               got.last_weight = rsp_tdata[31 +: WEIGHT_BITS];
               check_field("status", want.status, got.status);
               check_field("valve_is_open", want.valve_on, got.valve_on);
               check_field("servo_compare", want.servo, got.servo);
               check_field("phase", want.phase, got.phase);
               check_field("clog_flag", want.clog, got.clog);
               check_field("dose_count", want.doses, got.doses);
               check_field("final_weight_mg", $signed(want.last_weight),
                           $signed(got.last_weight));
            end
         end
      end
      fail_total  <= mismatches;
      reports_due <= dose_reports_due.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top level for the weighed dose dispense controller
// Drives directed and random dose command items into the controller under
// several register settings, with bursty requests and a stalling result
// side, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   import dwc_pkg::*;

   localparam int WB        = 26;
   localparam int REQ_W     = ((VOL_W + WB + 7) / 8) * 8;
   localparam int RSP_W     = ((3 + 1 + SERVO_W + 2 + 1 + COUNT_W + WB + 7) / 8) * 8;
   localparam int CHUNK     = 180;         // random items per register setting
   localparam int MAX_TICKS = 48;          // longest planned dispensing run
   localparam int LIMIT     = 1_500_000;   // cycles before the run is called hung

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // request side
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;     // volume_ml, weight_mg, zero pad
   logic [1:0]       req_tuser  = '0;     // command

   // result side
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;           // status, valve_is_open, servo_compare,
                                          // phase, clog_flag, dose_count,
                                          // final_weight_mg, zero pad

   // register writes
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_total;
   int reports_due;

   // register values as last written, for shaping the dose sequences
   int unsigned cur_density;
   int unsigned cur_spm;
   int unsigned cur_pct;

   int items_sent = 0;
   int burst_left = 0;
   int cycle_count;

   weighed_dose_dispense_controller_unit #(.WEIGHT_BITS(WB)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dose_checker #(.WEIGHT_BITS(WB)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_total  (fail_total),
      .reports_due (reports_due)
   );

   // Result side back-pressure: switch between a few stall patterns every so
   // often, including stretches where the receiver is always ready.
   int ready_mode = 0;
   int mode_left  = 0;
   int ready_tick = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 200);
      end else begin
         mode_left--;
      end
      ready_tick++;
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 1);
         2:       rsp_tready <= (ready_tick % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Hang guard: end the run once the cycle budget is spent.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Offer one item and hold it until the controller takes it. Items go out
   // in bursts; between bursts tvalid may drop for a random number of cycles.
   task automatic send_item(cmd_type cmd, logic [VOL_W-1:0] vol, logic signed [WB-1:0] w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 128)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_W - VOL_W - WB){1'b0}}, w, vol};
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
      burst_left--;
   endtask

   // Stop offering items and hold until every result has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (reports_due != 0)
         @(posedge clock);
   endtask

   // Write all three registers back to back; no item is in flight here.
   task automatic set_config(int unsigned density, int unsigned spm, int unsigned pct);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_DENSITY;
      csr_wdata <= CSR_DATA_W'(density);
      @(posedge clock);
      csr_index <= CSR_SPM;
      csr_wdata <= CSR_DATA_W'(spm);
      @(posedge clock);
      csr_index <= CSR_PCT;
      csr_wdata <= CSR_DATA_W'(pct);
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_density = density;
      cur_spm     = spm;
      cur_pct     = pct;
   endtask

   // Random item. During a dose it carries any volume, so busy starts cover
   // the whole field; while idle keep start volumes small so a stray dose
   // cannot run out of reach.
   task automatic noise_item(bit busy);
      cmd_type     cmd;
      int unsigned vol;
      cmd = cmd_type'($urandom_range(0, 3));
      vol = busy ? $urandom_range(0, 65535) : $urandom_range(0, 15);
      send_item(cmd, VOL_W'(vol), WB'($urandom()));
   endtask

   // One well-formed dose: start, weight ticks walking toward the target,
   // then either a tick that reaches it or a budget timeout followed by a
   // final tick placed around the clog threshold.
   task automatic run_dose();
      int unsigned vol;
      int unsigned pick;
      longint      tgt;
      longint      bud;
      longint      loss;
      longint      dev;
      int          w0;
      int          n;
      bit          reach;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         vol = 0;
      else if (pick < 3)
         vol = $urandom_range(0, 65535);
      else
         vol = $urandom_range(1, 20);
      tgt = longint'(vol) * cur_density;
      // keep the target inside the reachable weight swing
      if (tgt > 30_000_000) begin
         vol = $urandom_range(1, 20);
         tgt = longint'(vol) * cur_density;
      end
      bud   = longint'(vol) * cur_spm;
      reach = (bud > MAX_TICKS) || (bud > 0 && $urandom_range(0, 1) == 1);
      w0    = int'($urandom_range(0, 5_000_000)) - 2_000_000;
      send_item(CMD_START, VOL_W'(vol), WB'(w0));
      if (reach)
         n = $urandom_range(1, (bud > MAX_TICKS) ? MAX_TICKS : int'(bud));
      else
         n = int'(bud);
      for (int k = 1; k <= n; k++) begin
         if ($urandom_range(0, 5) == 0)
            noise_item(1'b1);
         if (reach && k == n)
            loss = tgt + $urandom_range(0, 3);
         else
            loss = (tgt * k) / (n + 1) - $urandom_range(0, 1);
         send_item(CMD_TICK, VOL_W'($urandom()), WB'(w0 - loss));
      end
      if (!reach) begin
         if ($urandom_range(0, 5) == 0)
            noise_item(1'b1);
         // place the deviation on, just past, or well away from the threshold
         case ($urandom_range(0, 3))
            0:       dev = (tgt * cur_pct) / 100;
            1:       dev = (tgt * cur_pct) / 100 + 1;
            2:       dev = $urandom_range(0, int'(2 * tgt) + 10);
            default: dev = ((tgt * cur_pct) / 100) / 2;
         endcase
         loss = $urandom_range(0, 1) ? tgt + dev : tgt - dev;
         send_item(CMD_TICK, VOL_W'($urandom()), WB'(w0 - loss));
      end
   endtask

   // Random part under the current registers: mostly complete doses, some
   // stray items, and now and then a full drain of the result side.
   task automatic random_chunk();
      int first;
      first = items_sent;
      while (items_sent - first < CHUNK) begin
         if ($urandom_range(0, 9) == 0)
            noise_item(1'b0);
         else
            run_dose();
         if ($urandom_range(0, 39) == 0)
            wait_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part: largest density, one sample per mL, zero tolerance
      set_config(4095, 1, 0);
      send_item(CMD_TICK,  16'd0,     26'sd33554431);  // tick while idle
      send_item(CMD_OPEN,  16'hFFFF,  -26'sd33554432); // manual open while idle
      send_item(CMD_CLOSE, 16'd0,     26'sd0);         // manual close while idle
      send_item(CMD_START, 16'd0,     26'sd0);         // zero budget, zero target
      send_item(CMD_START, 16'hFFFF,  26'sd33554431);  // start while awaiting final
      send_item(CMD_OPEN,  16'd0,     26'sd0);         // manual valve during a dose
      send_item(CMD_CLOSE, 16'd0,     26'sd0);
      send_item(CMD_TICK,  16'd0,     -26'sd1);        // zero target: clog at 0 pct
      send_item(CMD_TICK,  16'd0,     26'sd0);         // tick in error phase
      send_item(CMD_OPEN,  16'd0,     26'sd0);         // manual valve in error phase
      send_item(CMD_CLOSE, 16'd0,     26'sd0);
      send_item(CMD_START, 16'd1,     26'sd5000);      // start from error phase
      send_item(CMD_TICK,  16'd0,     26'sd905);       // loss equals target exactly
      send_item(CMD_START, 16'd2,     26'sd0);
      send_item(CMD_TICK,  16'd0,     -26'sd100);
      send_item(CMD_START, 16'd7,     26'sd0);         // start while dispensing
      send_item(CMD_TICK,  16'd0,     -26'sd200);      // budget runs out
      send_item(CMD_TICK,  16'd0,     -26'sd8190);     // no deviation: partial
      send_item(CMD_START, 16'd3,     26'sd33554431);
      send_item(CMD_TICK,  16'd0,     -26'sd33554432); // success at weight extremes
      send_item(CMD_START, 16'd1,     -26'sd33554432);
      send_item(CMD_TICK,  16'd0,     26'sd33554431);  // weight went up: timeout
      send_item(CMD_TICK,  16'd0,     26'sd33554431);  // far off target: clog

      // ---- random part over several register settings, extremes included
      set_config(DENSITY_RESET, SPM_RESET, PCT_RESET);
      random_chunk();
      set_config(1, 1, 0);
      random_chunk();
      set_config(4095, 255, 100);
      random_chunk();
      set_config($urandom_range(1, 4095), $urandom_range(1, 8), $urandom_range(0, 100));
      random_chunk();
      set_config(1, 3, 100);
      random_chunk();
      set_config($urandom_range(1, 4095), $urandom_range(1, 255), $urandom_range(0, 100));
      random_chunk();

      // ---- saturated target: the product overflows the target width, so a
      // truncated target would be tiny; a loss of 5000 mg and the largest
      // possible loss must both leave the dose running
      set_config(4095, 1, 50);
      send_item(CMD_START, 16'd32777, 26'sd33554431);
      send_item(CMD_TICK,  16'd0,     26'sd33549431);
      send_item(CMD_TICK,  16'd0,     -26'sd33554432);

      // ---- wind down: all results in, then a few cycles for strays
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_total == 0 && reports_due == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
